// File: src/crmu_pkg.sv
// ----------------------------------------------------------------------------
// crmu_pkg
// Shared types, constants and the divider step of the centroid running mean.
// ----------------------------------------------------------------------------
`default_nettype none

package crmu_pkg;

  localparam int unsigned DIM_DEF       = 64;
  localparam logic [31:0] MAX_COUNT_DEF = 32'd65535;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned POS_W = 11;
  localparam int unsigned CNT_W = 16;

  localparam int unsigned DIV_STAGES = 8;
  localparam int unsigned DIV_BITS   = 4;

  typedef struct packed {
    logic              upd;
    logic              last;
    logic              ovf;
    logic [IDX_W-1:0]  idx;
    logic signed [31:0] x;
    logic [CNT_W-1:0]  n_used;
    logic [CNT_W-1:0]  seen;
  } item_t;

  // four restoring division steps: returns {remainder, shifted word}
  function automatic logic [48:0] div4(logic [16:0] r, logic [31:0] l, logic [16:0] d);
    logic [17:0] t;
    logic [16:0] rr;
    logic [31:0] ll;
    rr = r;
    ll = l;
    for (int i = 0; i < DIV_BITS; i++) begin
      t  = {rr, ll[31]};
      ll = {ll[30:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t     = t - {1'b0, d};
        ll[0] = 1'b1;
      end
      rr = t[16:0];
    end
    return {rr, ll};
  endfunction

endpackage

`default_nettype wire

// File: src/crmu_front.sv
// ----------------------------------------------------------------------------
// crmu_front
// Accepts words, tracks position and member count, classifies each word.
// ----------------------------------------------------------------------------
`default_nettype none

module crmu_front #(
  parameter int unsigned DIM       = crmu_pkg::DIM_DEF,
  parameter logic [31:0] MAX_COUNT = crmu_pkg::MAX_COUNT_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic               kind_i,
  input  wire logic signed [31:0] component_value_i,
  input  wire logic               last_i,
  output crmu_pkg::item_t         item_o
);

  localparam logic [crmu_pkg::CNT_W-1:0] CAP =
    (MAX_COUNT > 32'd65535) ? 16'hFFFF : MAX_COUNT[crmu_pkg::CNT_W-1:0];
  localparam logic [crmu_pkg::POS_W-1:0] DIM_P = crmu_pkg::POS_W'(DIM);

  logic [crmu_pkg::POS_W-1:0] pos_q, pos_d;
  logic [crmu_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       ovf;

  always_comb begin
    ovf = pos_q >= DIM_P;
    cnt_d = kind_i ? cnt_q : '0;
    if (last_i && kind_i && cnt_q < CAP) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (last_i) begin
      pos_d = '0;
    end else if (!ovf) begin
      pos_d = pos_q + 1'b1;
    end else begin
      pos_d = pos_q;
    end
    item_o.upd    = kind_i;
    item_o.last   = last_i;
    item_o.ovf    = ovf;
    item_o.idx    = pos_q[crmu_pkg::IDX_W-1:0];
    item_o.x      = component_value_i;
    item_o.n_used = cnt_q;
    item_o.seen   = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cnt_q <= '0;
    end else if (accept_i) begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: src/crmu_fifo.sv
// ----------------------------------------------------------------------------
// crmu_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module crmu_fifo (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  crmu_pkg::item_t  item_i,
  input  wire logic        pop_i,
  output logic             full_o,
  output logic             nempty_o,
  output crmu_pkg::item_t  head_o
);

  crmu_pkg::item_t mem_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;

  assign full_o   = cnt_q[1];
  assign nempty_o = cnt_q != 2'd0;
  assign head_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/crmu_back.sv
// ----------------------------------------------------------------------------
// crmu_back
// Store read, multiply-add, pipelined divide, store write and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crmu_back #(
  parameter int unsigned DIM = crmu_pkg::DIM_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               nempty_i,
  input  crmu_pkg::item_t         head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      centroid_value_o,
  output logic [5:0]              component_index_o,
  output logic [15:0]             members_seen_o,
  output logic                    end_of_vector_o,
  output logic                    overflow_o
);

  localparam int unsigned IW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned ND = crmu_pkg::DIV_STAGES;
  localparam int unsigned NS = 4 + ND;

  logic signed [31:0] store_q [DIM];

  crmu_pkg::item_t    it_q [NS];
  logic [NS-1:0]      v_q;
  logic signed [31:0] c1_q;
  logic signed [49:0] prod2_q;
  logic signed [48:0] sum3_q;
  logic [16:0]        rem_q [ND+1];
  logic [31:0]        low_q [ND+1];
  logic [16:0]        den_q [ND+1];
  logic               neg_q [ND+1];

  logic               en, hazard, wr;
  logic [48:0]        negs;
  logic [31:0]        qv, res;
  crmu_pkg::item_t    tail;

  assign en   = !out_valid_o || !out_stall_i;
  assign tail = it_q[NS-1];

  always_comb begin
    hazard = 1'b0;
    for (int s = 0; s < NS; s++) begin
      if (v_q[s] && !it_q[s].ovf && it_q[s].idx == head_i.idx) begin
        hazard = 1'b1;
      end
    end
    hazard = hazard && head_i.upd && !head_i.ovf;
    pop_o  = en && nempty_i && !hazard;
    negs   = -sum3_q;
    qv     = neg_q[ND] ? -low_q[ND] : low_q[ND];
    if (tail.ovf) begin
      res = '0;
    end else if (tail.upd) begin
      res = qv;
    end else begin
      res = tail.x;
    end
    wr = en && v_q[NS-1] && !tail.ovf;
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      store_q[tail.idx[IW-1:0]] <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      c1_q <= store_q[head_i.idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it_q[0] <= head_i;
      for (int s = 1; s < NS; s++) begin
        it_q[s] <= it_q[s-1];
      end
      prod2_q <= $signed({1'b0, {1'b0, it_q[0].n_used} + 17'd1}) * c1_q;
      sum3_q  <= prod2_q[48:0] + {{17{it_q[1].x[31]}}, it_q[1].x};
      neg_q[0] <= sum3_q[48];
      den_q[0] <= {1'b0, it_q[2].n_used} + 17'd2;
      rem_q[0] <= {1'b0, sum3_q[48] ? negs[47:32] : sum3_q[47:32]};
      low_q[0] <= sum3_q[48] ? negs[31:0] : sum3_q[31:0];
      for (int k = 1; k <= ND; k++) begin
        {rem_q[k], low_q[k]} <= crmu_pkg::div4(rem_q[k-1], low_q[k-1], den_q[k-1]);
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[NS-2:0], pop_o};
      out_valid_o <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      centroid_value_o  <= res;
      component_index_o <= tail.ovf ? 6'd63 : tail.idx[5:0];
      members_seen_o    <= tail.seen;
      end_of_vector_o   <= tail.last;
      overflow_o        <= tail.ovf;
    end
  end

endmodule

`default_nettype wire

// File: src/centroid_running_mean_update.sv
// ----------------------------------------------------------------------------
// centroid_running_mean_update
// Running-mean update of one k-means centroid, one component per word.
//
// Input channel: in_valid_i / in_stall_o with kind_i, component_value_i and
// last_i. A load word stores the component and clears the member count; an
// update word folds it into the stored component as ((n+1)*c + x)/(n+2),
// truncated toward zero. Output channel: out_valid_o / out_stall_i, one word
// out for every word in, in order.
// Throughput: one word per cycle while the output is not stalled and no
// update touches a component still in flight. Such an update waits until
// that write lands, so vectors shorter than the pipeline depth run slower;
// with single-component vectors each word waits until the one before is written.
// From acceptance to out_valid_o a word passes the queue, store read,
// multiply, add, magnitude, eight 4-bit divider stages and the output register.
// Reset clears position, member count and all valid flags; the centroid store
// is not cleared and must be loaded before it is updated. A stall on the
// output freezes the whole pipeline; the two-word queue keeps accepting
// until it fills, then in_stall_o rises.
// ----------------------------------------------------------------------------
`default_nettype none

module centroid_running_mean_update #(
  parameter int unsigned DIM       = crmu_pkg::DIM_DEF,
  parameter logic [31:0] MAX_COUNT = crmu_pkg::MAX_COUNT_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               kind_i,
  input  wire logic signed [31:0] component_value_i,
  input  wire logic               last_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      centroid_value_o,
  output logic [5:0]              component_index_o,
  output logic [15:0]             members_seen_o,
  output logic                    end_of_vector_o,
  output logic                    overflow_o
);

  crmu_pkg::item_t item, head;
  logic            accept, full, nempty, pop;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  crmu_front #(
    .DIM       (DIM),
    .MAX_COUNT (MAX_COUNT)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .kind_i            (kind_i),
    .component_value_i (component_value_i),
    .last_i            (last_i),
    .item_o            (item)
  );

  crmu_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept),
    .item_i   (item),
    .pop_i    (pop),
    .full_o   (full),
    .nempty_o (nempty),
    .head_o   (head)
  );

  crmu_back #(
    .DIM (DIM)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .nempty_i          (nempty),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .centroid_value_o  (centroid_value_o),
    .component_index_o (component_index_o),
    .members_seen_o    (members_seen_o),
    .end_of_vector_o   (end_of_vector_o),
    .overflow_o        (overflow_o)
  );

endmodule

`default_nettype wire
